// ===== sv/random_probe_block_allocator_macros.svh =====
// Assertion macros shared by the allocator checker.
`ifndef RANDOM_PROBE_BLOCK_ALLOCATOR_MACROS_SVH
`define RANDOM_PROBE_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPBA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rpba_pkg.sv =====
// Shared types and constants for the random probe block allocator.
package rpba_pkg;

  localparam int KIND_W       = 2;
  localparam int IDX_PORT_W   = 12;
  localparam int CNT_PORT_W   = 13;
  localparam int STATUS_W     = 3;
  localparam int PICK_W       = 64;
  localparam int CHANCE_W     = 32;
  localparam int STEP_W       = 6;
  localparam int RESERVE_W    = 7;
  localparam int SHRED_W      = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam int CHANCE_MOD   = 1000;
  // floor(x / 1000) == (x * CHANCE_RECIP) >> CHANCE_SHIFT for any 32-bit x
  localparam int CHANCE_RECIP = 274877907;
  localparam int CHANCE_SHIFT = 38;
  localparam int CHQ_W        = 23;
  localparam int FEW_FREE     = 5;
  localparam int PCT_FULL     = 100;
  localparam int RESERVE_RST  = 5;
  localparam int SHRED_RST    = 5;
  localparam int INIT_RST     = 4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USED  = 2'd2,
    KIND_SHRED = 2'd3
  } kind_t;

  localparam logic [STATUS_W-1:0] STAT_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FREE_TWICE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BUSY_TWICE = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NO_SHRED   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_MODC,
    S_MODP,
    S_SCAN,
    S_MARK,
    S_EMIT
  } phase_t;

endpackage

// ===== sv/rpba_mod.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor.
module rpba_mod
  import rpba_pkg::*;
#(
  parameter int DW = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [PICK_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     rem
);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [PICK_W-1:0] num_r;
  logic [DW-1:0]     den_r;
  logic [DW-1:0]     rem_r;

  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_nxt;

  // restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, num_r[PICK_W-1]};
    diff    = trial - {1'b0, den_r};
    rem_nxt = (trial >= {1'b0, den_r}) ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == STEP_W'(PICK_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt_r <= '0;
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + STEP_W'(1);
      num_r <= {num_r[PICK_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/random_probe_block_allocator.sv =====
// Mark free and mark used pass through a mark step before their result is emitted; an index out
// of range goes straight to the result. A probing allocate or shred tick runs a 64-step serial
// remainder, then tests one busy bit per cycle; a scan from block zero skips the remainder.
// Refusals by the reserve check and missed or frozen shreds go to the result without a probe.
// One item is worked at a time; the next is taken the cycle after a result is loaded.
// Reset, and any write of the initial block count, runs a clearing pass over all MAX_BLOCKS blocks.
module random_probe_block_allocator
  import rpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic                  in_privileged,
  input  logic [IDX_PORT_W-1:0] in_block_index,
  input  logic [PICK_W-1:0]     in_rand_pick,
  input  logic [CHANCE_W-1:0]   in_rand_chance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IDX_PORT_W-1:0] out_result_block,
  output logic                  out_grew,
  output logic                  out_read_only,
  output logic [CNT_PORT_W-1:0] out_busy_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int EW    = (CNT_W > CNT_PORT_W) ? CNT_W : CNT_PORT_W;
  localparam int DW    = CNT_W;
  localparam int PW    = CNT_W + RESERVE_W;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_PORT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (EW'(v) > EW'(MAX_BLOCKS)) return CNT_W'(MAX_BLOCKS);
    return CNT_W'(v);
  endfunction

  // bitmap memory
  logic busy_mem [MAX_BLOCKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic             mem_wd;
  logic [IDX_W-1:0] mem_ra;
  logic             rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) busy_mem[mem_wa] <= mem_wd;
    rd_r <= busy_mem[mem_ra];
  end

  // remainder unit
  logic              mod_go;
  logic [PICK_W-1:0] mod_dividend;
  logic [DW-1:0]     mod_divisor;
  logic              mod_done;
  logic [DW-1:0]     mod_rem;

  rpba_mod #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  phase_t                state_r, state_nxt;
  logic [RESERVE_W-1:0]  reserve_r, reserve_nxt;
  logic [SHRED_W-1:0]    shred_r, shred_nxt;
  logic [CNT_W-1:0]      busy_r, busy_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic                  frozen_r, frozen_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      issued_r, issued_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]      chk_pos_r, chk_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;

  kind_t                 kind_r, kind_nxt;
  logic                  priv_r, priv_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [PICK_W-1:0]     pick_r, pick_nxt;
  logic [CHANCE_W-1:0]   chance_r, chance_nxt;
  logic [CHQ_W-1:0]      chq_r, chq_nxt;
  logic [PW-1:0]         prodb_r, prodb_nxt;
  logic [PW-1:0]         prodl_r, prodl_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [IDX_W-1:0]      res_block_r, res_block_nxt;
  logic                  res_grew_r, res_grew_nxt;
  logic                  out_load;

  logic [STATUS_W-1:0]   out_status_r;
  logic [IDX_PORT_W-1:0] out_block_r;
  logic                  out_grew_r;
  logic                  out_ro_r;
  logic [CNT_PORT_W-1:0] out_busy_r;

  logic [RESERVE_W-1:0]  res_pct;
  logic [RESERVE_W-1:0]  pct_left;
  logic [PICK_W-1:0]     chance_prod;
  logic [CHANCE_W-1:0]   chance_rem;

  always_comb begin
    res_pct  = (reserve_r > RESERVE_W'(PCT_FULL)) ? RESERVE_W'(PCT_FULL) : reserve_r;
    pct_left = RESERVE_W'(PCT_FULL) - res_pct;
    // quotient of the chance word by 1000, taken at accept; remainder in the next cycle
    chance_prod = PICK_W'(in_rand_chance) * PICK_W'(CHANCE_RECIP);
    chance_rem  = chance_r - CHANCE_W'(chq_r) * CHANCE_W'(CHANCE_MOD);
  end

  always_comb begin
    state_nxt      = state_r;
    reserve_nxt    = reserve_r;
    shred_nxt      = shred_r;
    busy_nxt       = busy_r;
    live_nxt       = live_r;
    frozen_nxt     = frozen_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    issued_nxt     = issued_r;
    chk_v_nxt      = chk_v_r;
    chk_pos_nxt    = chk_pos_r;
    kind_nxt       = kind_r;
    priv_nxt       = priv_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    chance_nxt     = chance_r;
    chq_nxt        = chq_r;
    prodb_nxt      = prodb_r;
    prodl_nxt      = prodl_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    res_grew_nxt   = res_grew_r;
    out_load       = 1'b0;
    in_stall       = 1'b1;
    mem_we         = 1'b0;
    mem_wa         = chk_pos_r;
    mem_wd         = 1'b0;
    mem_ra         = pos_r;
    mod_go         = 1'b0;
    mod_dividend   = pick_r;
    mod_divisor    = DW'(live_r);

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 1'b0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(MAX_BLOCKS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        in_stall = 1'b0;
        mem_ra   = IDX_W'(in_block_index);
        if (in_valid) begin
          kind_nxt       = kind_t'(in_kind);
          priv_nxt       = in_privileged;
          idx_nxt        = IDX_W'(in_block_index);
          pick_nxt       = in_rand_pick;
          res_status_nxt = STAT_DONE;
          res_block_nxt  = '0;
          res_grew_nxt   = 1'b0;
          case (kind_t'(in_kind))
            KIND_ALLOC: begin
              prodb_nxt = PW'(busy_r) * PW'(PCT_FULL);
              prodl_nxt = PW'(live_r) * PW'(pct_left);
              state_nxt = S_CHECK;
            end
            KIND_FREE, KIND_USED: begin
              // out-of-range index is ignored with status done
              if (EW'(in_block_index) < EW'(live_r)) state_nxt = S_MARK;
              else state_nxt = S_EMIT;
            end
            KIND_SHRED: begin
              res_status_nxt = STAT_NO_SHRED;
              chance_nxt     = in_rand_chance;
              chq_nxt        = chance_prod[CHANCE_SHIFT +: CHQ_W];
              if (frozen_r) state_nxt = S_EMIT;
              else state_nxt = S_MODC;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_CHECK: begin
        if (!priv_r && prodb_r >= prodl_r) begin
          res_status_nxt = STAT_NO_SPACE;
          state_nxt      = S_EMIT;
        end else if ((CNT_W+1)'(busy_r) + (CNT_W+1)'(FEW_FREE) < (CNT_W+1)'(live_r)) begin
          mod_go    = 1'b1;
          state_nxt = S_MODP;
        end else begin
          // few blocks left: scan from block zero
          pos_nxt    = '0;
          issued_nxt = '0;
          chk_v_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_MODC: begin
        if (chance_rem < CHANCE_W'(shred_r)) begin
          mod_go    = 1'b1;
          state_nxt = S_MODP;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_MODP: begin
        if (mod_done) begin
          pos_nxt    = IDX_W'(mod_rem);
          issued_nxt = '0;
          chk_v_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // each read is registered and meets its free test in the next cycle
        mem_ra = pos_r;
        if (chk_v_r && !rd_r) begin
          res_block_nxt = chk_pos_r;
          if (kind_r == KIND_ALLOC) begin
            mem_we   = 1'b1;
            mem_wa   = chk_pos_r;
            mem_wd   = 1'b1;
            busy_nxt = busy_r + CNT_W'(1);
          end else begin
            res_status_nxt = STAT_DONE;
          end
          state_nxt = S_EMIT;
        end else if (chk_v_r && issued_r == live_r) begin
          if (kind_r == KIND_ALLOC) begin
            if (priv_r && live_r < CNT_W'(MAX_BLOCKS)) begin
              // emergency growth by one block
              mem_we        = 1'b1;
              mem_wa        = IDX_W'(live_r);
              mem_wd        = 1'b1;
              res_block_nxt = IDX_W'(live_r);
              live_nxt      = live_r + CNT_W'(1);
              busy_nxt      = busy_r + CNT_W'(1);
              frozen_nxt    = 1'b1;
              res_grew_nxt  = 1'b1;
            end else begin
              res_status_nxt = STAT_NO_SPACE;
            end
          end
          state_nxt = S_EMIT;
        end else if (issued_r != live_r) begin
          chk_v_nxt   = 1'b1;
          chk_pos_nxt = pos_r;
          issued_nxt  = issued_r + CNT_W'(1);
          if (CNT_W'(pos_r) + CNT_W'(1) == live_r) pos_nxt = '0;
          else pos_nxt = pos_r + IDX_W'(1);
        end else begin
          chk_v_nxt = 1'b0;
        end
      end

      S_MARK: begin
        mem_wa = idx_r;
        if (kind_r == KIND_FREE) begin
          if (!rd_r) begin
            res_status_nxt = STAT_FREE_TWICE;
          end else begin
            mem_we   = 1'b1;
            mem_wd   = 1'b0;
            busy_nxt = busy_r - CNT_W'(1);
          end
        end else begin
          if (rd_r) begin
            res_status_nxt = STAT_BUSY_TWICE;
          end else begin
            mem_we   = 1'b1;
            mem_wd   = 1'b1;
            busy_nxt = busy_r + CNT_W'(1);
          end
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        CFG_RESERVE: reserve_nxt = cfg_wdata[RESERVE_W-1:0];
        CFG_SHRED:   shred_nxt   = cfg_wdata[SHRED_W-1:0];
        CFG_INIT: begin
          live_nxt   = clamp_count(cfg_wdata);
          busy_nxt   = '0;
          frozen_nxt = 1'b0;
          clr_nxt    = '0;
          state_nxt  = S_CLEAR;
        end
        default: ;
      endcase
    end

    out_valid_nxt = out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      reserve_r   <= RESERVE_W'(RESERVE_RST);
      shred_r     <= SHRED_W'(SHRED_RST);
      busy_r      <= '0;
      live_r      <= clamp_count(CNT_PORT_W'(INIT_RST));
      frozen_r    <= 1'b0;
      clr_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reserve_r   <= reserve_nxt;
      shred_r     <= shred_nxt;
      busy_r      <= busy_nxt;
      live_r      <= live_nxt;
      frozen_r    <= frozen_nxt;
      clr_r       <= clr_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    issued_r     <= issued_nxt;
    chk_pos_r    <= chk_pos_nxt;
    kind_r       <= kind_nxt;
    priv_r       <= priv_nxt;
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    chance_r     <= chance_nxt;
    chq_r        <= chq_nxt;
    prodb_r      <= prodb_nxt;
    prodl_r      <= prodl_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    res_grew_r   <= res_grew_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_block_r  <= IDX_PORT_W'(res_block_r);
      out_grew_r   <= res_grew_r;
      out_ro_r     <= frozen_r;
      out_busy_r   <= CNT_PORT_W'(busy_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_block = out_block_r;
  assign out_grew         = out_grew_r;
  assign out_read_only    = out_ro_r;
  assign out_busy_total   = out_busy_r;

endmodule

// ===== sv/rpba_chk.sv =====
// Port-level checker for the allocator, bound to the top level.
`include "random_probe_block_allocator_macros.svh"

module rpba_chk
  import rpba_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   out_status,
  input logic [IDX_PORT_W-1:0] out_result_block,
  input logic                  out_grew,
  input logic                  out_read_only
);

  // one item in flight: an accept closes the input side next cycle
  `RPBA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken early")

  // growth only on a successful allocate, and it freezes the store
  `RPBA_ASSERT_NOW(a_grew_freeze, out_valid && out_grew, out_read_only && out_status == STAT_DONE, "growth without freeze")

  // refusals and warnings carry no block
  `RPBA_ASSERT_NOW(a_fail_block, out_valid && out_status != STAT_DONE, out_result_block == '0 && !out_grew, "block on failed item")

  `RPBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_result_block), "stalled result changed")

endmodule

bind random_probe_block_allocator rpba_chk u_rpba_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_result_block (out_result_block),
  .out_grew         (out_grew),
  .out_read_only    (out_read_only)
);

// ===== sim/tb.sv =====
// Testbench for the random probe block allocator: predictor, driver, monitor and checks.
module tb;
  import rpba_pkg::*;

  localparam int NBLK = 4096;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    kind_t                 kind;
    logic                  priv;
    logic [IDX_PORT_W-1:0] idx;
    logic [PICK_W-1:0]     pick;
    logic [CHANCE_W-1:0]   chance;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [IDX_PORT_W-1:0] blk;
    logic                  grew;
    logic                  ro;
    logic [CNT_PORT_W-1:0] busy;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind = '0;
  logic                  in_privileged = 1'b0;
  logic [IDX_PORT_W-1:0] in_block_index = '0;
  logic [PICK_W-1:0]     in_rand_pick = '0;
  logic [CHANCE_W-1:0]   in_rand_chance = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_PORT_W-1:0] out_result_block;
  logic                  out_grew;
  logic                  out_read_only;
  logic [CNT_PORT_W-1:0] out_busy_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predicted allocator state and registers
  bit          pred_busy [NBLK];
  int unsigned busy_n;
  int unsigned live_n;
  bit          ro;
  int unsigned reserve_pct;
  int unsigned shred_pm;
  int unsigned init_cnt;

  request_t requests_todo[$];
  reply_t   replies_due[$];
  request_t cur_req;
  reply_t   want;
  int       gap_max = 17;
  int       stall_max = 17;
  int       gap_left = 0;
  int       stall_left = 0;
  int       hold_cycles = 0;
  int       errors = 0;

  always #5 clk = ~clk;

  random_probe_block_allocator #(.MAX_BLOCKS(NBLK)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_privileged    (in_privileged),
    .in_block_index   (in_block_index),
    .in_rand_pick     (in_rand_pick),
    .in_rand_chance   (in_rand_chance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_grew         (out_grew),
    .out_read_only    (out_read_only),
    .out_busy_total   (out_busy_total),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic void reload_map();
    int unsigned n;
    n = init_cnt;
    if (n < 1) n = 1;
    if (n > NBLK) n = NBLK;
    foreach (pred_busy[i]) pred_busy[i] = 1'b0;
    busy_n = 0;
    live_n = n;
    ro = 1'b0;
  endfunction

  // circular search over the live blocks
  function automatic bit first_free(int unsigned start, output int unsigned blk);
    int unsigned p;
    p = start;
    blk = 0;
    for (int unsigned k = 0; k < live_n; k++) begin
      if (!pred_busy[p]) begin
        blk = p;
        return 1'b1;
      end
      p++;
      if (p >= live_n) p = 0;
    end
    return 1'b0;
  endfunction

  function automatic reply_t allocator_reply(request_t rq);
    reply_t      r;
    int unsigned res;
    int unsigned start;
    int unsigned got;
    r = '{default: '0};
    case (rq.kind)
      KIND_ALLOC: begin
        res = (reserve_pct > PCT_FULL) ? PCT_FULL : reserve_pct;
        if (!rq.priv && busy_n * PCT_FULL >= live_n * (PCT_FULL - res)) begin
          r.status = STAT_NO_SPACE;
        end else begin
          start = 0;
          if (busy_n + FEW_FREE < live_n) start = 32'(rq.pick % live_n);
          if (first_free(start, got)) begin
            pred_busy[got] = 1'b1;
            busy_n++;
            r.blk = got[IDX_PORT_W-1:0];
          end else if (rq.priv && live_n < NBLK) begin
            // emergency growth: take the new block and freeze the store
            r.blk = live_n[IDX_PORT_W-1:0];
            pred_busy[live_n] = 1'b1;
            live_n++;
            busy_n++;
            ro = 1'b1;
            r.grew = 1'b1;
          end else begin
            r.status = STAT_NO_SPACE;
          end
        end
      end
      KIND_FREE: begin
        if (rq.idx < live_n) begin
          if (!pred_busy[rq.idx]) r.status = STAT_FREE_TWICE;
          else begin
            pred_busy[rq.idx] = 1'b0;
            busy_n--;
          end
        end
      end
      KIND_USED: begin
        if (rq.idx < live_n) begin
          if (pred_busy[rq.idx]) r.status = STAT_BUSY_TWICE;
          else begin
            pred_busy[rq.idx] = 1'b1;
            busy_n++;
          end
        end
      end
      default: begin
        r.status = STAT_NO_SHRED;
        if (!ro && rq.chance % CHANCE_MOD < shred_pm) begin
          if (first_free(32'(rq.pick % live_n), got)) begin
            r.status = STAT_DONE;
            r.blk = got[IDX_PORT_W-1:0];
          end
        end
      end
    endcase
    r.ro = ro;
    r.busy = busy_n[CNT_PORT_W-1:0];
    return r;
  endfunction

  function automatic void push_req(kind_t k, logic priv, logic [IDX_PORT_W-1:0] idx,
                                   logic [PICK_W-1:0] pick, logic [CHANCE_W-1:0] chance);
    request_t rq;
    rq.kind = k;
    rq.priv = priv;
    rq.idx = idx;
    rq.pick = pick;
    rq.chance = chance;
    requests_todo.push_back(rq);
  endfunction

  function automatic request_t random_req();
    request_t    rq;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 35) rq.kind = KIND_ALLOC;
    else if (roll < 60) rq.kind = KIND_FREE;
    else if (roll < 80) rq.kind = KIND_USED;
    else rq.kind = KIND_SHRED;
    rq.priv = 1'($urandom_range(1, 0));
    // mostly live blocks, some noise across the whole index range
    if ($urandom_range(9, 0) < 8) rq.idx = 12'($urandom_range(live_n + 1, 0));
    else rq.idx = 12'($urandom);
    rq.pick = {$urandom, $urandom};
    if ($urandom_range(1, 0) == 1) rq.chance = $urandom;
    else rq.chance = $urandom_range(1999, 0);
    return rq;
  endfunction

  function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    logic [CFG_DATA_W-1:0] v;
    v = val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_RESERVE: reserve_pct = v[RESERVE_W-1:0];
      CFG_SHRED:   shred_pm = v[SHRED_W-1:0];
      CFG_INIT: begin
        init_cnt = v;
        reload_map();
      end
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0);
  endtask

  task automatic random_phase(int unsigned res_v, int unsigned shred_v, int unsigned init_v,
                              int n, int gap_lim, int stall_lim, int hold_len);
    set_reg(CFG_RESERVE, res_v);
    set_reg(CFG_SHRED, shred_v);
    set_reg(CFG_INIT, init_v);
    close_cfg();
    gap_max = gap_lim;
    stall_max = stall_lim;
    repeat (n) requests_todo.push_back(random_req());
    if (hold_len > 0) begin
      // hold results back once the block has started, so the input backs up
      while (replies_due.size() == 0) @(negedge clk);
      hold_cycles = hold_len;
    end
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(allocator_reply(cur_req));
        gap_left = $urandom_range(gap_max, 0);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || requests_todo.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_req = requests_todo.pop_front();
          in_kind <= cur_req.kind;
          in_privileged <= cur_req.priv;
          in_block_index <= cur_req.idx;
          in_rand_pick <= cur_req.pick;
          in_rand_chance <= cur_req.chance;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0d block %0d",
                   $time, out_status, out_result_block);
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("result_block", want.blk, out_result_block);
          check_field("grew", want.grew, out_grew);
          check_field("read_only", want.ro, out_read_only);
          check_field("busy_total", want.busy, out_busy_total);
        end
        stall_left = $urandom_range(stall_max, 0);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    reserve_pct = RESERVE_RST;
    shred_pm = SHRED_RST;
    init_cnt = INIT_RST;
    reload_map();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the clearing pass
    do @(negedge clk); while (in_stall);

    // reset settings, full-size map
    push_req(KIND_ALLOC, 1'b0, 12'd0, '1, 32'd0);
    push_req(KIND_ALLOC, 1'b1, 12'd0, '0, 32'd0);
    push_req(KIND_USED, 1'b0, 12'd4095, '0, 32'd0);
    push_req(KIND_FREE, 1'b1, 12'd4095, '0, 32'd0);
    push_req(KIND_FREE, 1'b0, 12'd4095, '1, '1);
    push_req(KIND_USED, 1'b1, 12'd0, '0, 32'd0);
    push_req(KIND_SHRED, 1'b0, 12'd0, '0, '1);
    push_req(KIND_SHRED, 1'b0, 12'd0, '1, 32'd4004);
    push_req(KIND_SHRED, 1'b1, '1, '0, 32'd0);
    drain();

    // tiny map: fill, shred on a full map, refuse, then emergency growth
    set_reg(CFG_RESERVE, 0);
    set_reg(CFG_SHRED, 1000);
    set_reg(CFG_INIT, 6);
    close_cfg();
    repeat (6) push_req(KIND_ALLOC, 1'b1, 12'd0, {$urandom, $urandom}, 32'd0);
    push_req(KIND_SHRED, 1'b0, 12'd0, '0, 32'd0);
    push_req(KIND_ALLOC, 1'b0, 12'd0, '0, 32'd0);
    push_req(KIND_USED, 1'b0, 12'd4095, '0, 32'd0);
    push_req(KIND_ALLOC, 1'b1, 12'd0, '0, 32'd0);
    push_req(KIND_SHRED, 1'b0, 12'd0, '0, 32'd0);
    push_req(KIND_FREE, 1'b0, 12'd6, '0, 32'd0);
    drain();

    // reserve above hundred, count clamped up to one, zero shred chance
    set_reg(CFG_UNUSED, $urandom);
    set_reg(CFG_RESERVE, 127);
    set_reg(CFG_SHRED, 0);
    set_reg(CFG_INIT, 0);
    close_cfg();
    push_req(KIND_ALLOC, 1'b0, 12'd0, '1, 32'd0);
    push_req(KIND_ALLOC, 1'b1, 12'd0, '1, 32'd0);
    push_req(KIND_SHRED, 1'b0, 12'd0, '0, 32'd0);
    push_req(KIND_FREE, 1'b0, 12'd0, '0, 32'd0);
    drain();

    // random traffic over several settings
    random_phase(0, 1000, 8191, 20, 17, 17, 0);
    random_phase(50, 500, 12, 25, 0, 17, 400);
    random_phase($urandom_range(100, 0), $urandom_range(1023, 0), 40, 25, 0, 0, 0);
    random_phase($urandom_range(127, 0), $urandom_range(1023, 0), $urandom_range(64, 1),
                 25, 17, 17, 0);
    random_phase(100, 1023, 7, 20, 17, 17, 0);

    repeat (4300) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #30000000;
    $display("FAIL");
    $finish;
  end

endmodule
